>>> rtl/bfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfl_pkg: shared types and constants for the bounded free list
// Word layouts, request and status codes, list sizing and sequencer states.
// ----------------------------------------------------------------------------
package bfl_pkg;

	localparam int CAPACITY   = 16;
	localparam int BLOCK_BITS = 16;

	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W = $clog2(CAPACITY + 1);

	localparam int KIND_W        = 3;
	localparam int BLOCK_ID_W    = 16;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 5;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIND       = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [BLOCK_ID_W-1:0] block_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [BLOCK_ID_W-1:0]    result_block;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHUP,
		S_SCAN,
		S_SHDN,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

>>> rtl/bounded_free_list.sv
`default_nettype none
// Throughput: one request at a time; the entry array has one read and one
// write port and the sequencer walks it one entry per cycle.
// A finished result waits in an output register while the next request is taken.
// Reset clears the entry count, the sequencer state and the output valid; the entry array is not reset.
// ----------------------------------------------------------------------------
// bounded_free_list: ordered list of free block numbers
// Push front/back, pop front, remove first match and find, sequenced over
// an entry array with one read and one write port and one compare per cycle.
// ----------------------------------------------------------------------------
module bounded_free_list (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bfl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bfl_pkg::rsp_t      rsp
);
	import bfl_pkg::*;

	logic [BLOCK_BITS-1:0] list_q [CAPACITY];

	state_t                state_q, state_d;
	logic [KIND_W-1:0]     kind_q, kind_d;
	logic [BLOCK_BITS-1:0] blk_q, blk_d;
	logic [IDX_W-1:0]      ptr_q, ptr_d;
	logic [COUNT_W-1:0]    count_q, count_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic [BLOCK_BITS-1:0] res_q, res_d;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [BLOCK_BITS-1:0] wr_data;
	logic [IDX_W-1:0]      rd_idx;
	logic [BLOCK_BITS-1:0] rd_data_q;
	logic                  rsp_load;
	logic [COUNT_W-1:0]    ptr_nxt;
	logic                  full;
	logic                  empty;

	assign ptr_nxt = COUNT_W'(ptr_q) + COUNT_W'(1);
	assign full    = (count_q == COUNT_W'(CAPACITY));
	assign empty   = (count_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_q[wr_idx] <= wr_data;
		end
		rd_data_q <= list_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		blk_q    <= blk_d;
		ptr_q    <= ptr_d;
		status_q <= status_d;
		res_q    <= res_d;
		if (rsp_load) begin
			rsp_q.status       <= status_q;
			rsp_q.result_block <= BLOCK_ID_W'(res_q);
			rsp_q.entry_count  <= ENTRY_COUNT_W'(count_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		blk_d     = blk_q;
		ptr_d     = ptr_q;
		count_d   = count_q;
		status_d  = status_q;
		res_d     = res_q;
		wr_en     = 1'b0;
		wr_idx    = ptr_q;
		wr_data   = blk_q;
		rsp_load  = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					kind_d   = req.kind;
					blk_d    = req.block_id[BLOCK_BITS-1:0];
					status_d = ST_OK;
					res_d    = '0;
					ptr_d    = '0;
					case (req.kind) inside
						KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
							if (full) begin
								status_d = ST_FULL;
								state_d  = S_FIN;
							end else begin
								ptr_d   = count_q[IDX_W-1:0];
								state_d = S_SHUP;
							end
						end
						KIND_POP_FRONT: begin
							if (empty) begin
								status_d = ST_EMPTY;
								state_d  = S_FIN;
							end else begin
								state_d = S_SCAN;
							end
						end
						KIND_REMOVE, KIND_FIND: begin
							if (empty) begin
								status_d = ST_MISSING;
								state_d  = S_FIN;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_SHUP: begin
				// push front: move entries up one place from the top, then drop the new block in; push back writes it at the end
				wr_en  = 1'b1;
				if (kind_q == KIND_PUSH_BACK || ptr_q == '0) begin
					wr_data = blk_q;
					count_d = count_q + COUNT_W'(1);
					res_d   = blk_q;
					state_d = S_FIN;
				end else begin
					wr_data = rd_data_q;
					ptr_d   = ptr_q - IDX_W'(1);
				end
			end
			S_SCAN: begin
				// pop is a remove that matches the front entry
				if (kind_q == KIND_POP_FRONT || rd_data_q == blk_q) begin
					res_d   = rd_data_q;
					state_d = (kind_q == KIND_FIND) ? S_FIN : S_SHDN;
				end else if (ptr_nxt == count_q) begin
					status_d = ST_MISSING;
					state_d  = S_FIN;
				end else begin
					ptr_d = ptr_q + IDX_W'(1);
				end
			end
			S_SHDN: begin
				// close the gap left by the removed entry
				if (ptr_nxt == count_q) begin
					count_d = count_q - COUNT_W'(1);
					state_d = S_FIN;
				end else begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
					ptr_d   = ptr_q + IDX_W'(1);
				end
			end
			S_FIN: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// fetch the entry that the next state looks at
		unique case (state_d)
			S_SHUP:  rd_idx = ptr_d - IDX_W'(1);
			S_SHDN:  rd_idx = ptr_d + IDX_W'(1);
			default: rd_idx = ptr_d;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> COUNT_W'(ptr_q) < count_q)
		else $error("scan pointer past last entry");

	a_shdn_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHDN |-> count_q != '0)
		else $error("removal on empty list");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.result_block == '0)
		else $error("failed request returned a block");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHUP && state_d == S_FIN |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("push did not grow the list by one");
`endif

endmodule

`default_nettype wire

>>> verif/bounded_free_list_checker.sv
// ----------------------------------------------------------------------------
// bounded_free_list_checker: request/response scoreboard for the free list
// Watches both channels, keeps its own copy of the block list and compares
// every response word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bounded_free_list_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire bfl_pkg::req_t  req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_ready,
	input  wire bfl_pkg::rsp_t  rsp,
	output int                  mismatches,
	output int                  awaited_words
);
	import bfl_pkg::*;

	localparam logic [BLOCK_ID_W-1:0] ID_MASK = (BLOCK_BITS >= BLOCK_ID_W) ?
		{BLOCK_ID_W{1'b1}} : BLOCK_ID_W'((64'd1 << BLOCK_BITS) - 64'd1);

	logic [BLOCK_ID_W-1:0] free_blocks[$];
	rsp_t                  awaited_rsp[$];

	initial begin
		mismatches    = 0;
		awaited_words = 0;
	end

	// Apply one request to the shadow list and return the word it should produce.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t                  o;
		logic [BLOCK_ID_W-1:0] blk;
		int                    hit;
		o      = '0;
		o.status = ST_OK;
		blk    = r.block_id & ID_MASK;
		hit    = -1;
		case (r.kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (free_blocks.size() >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					if (r.kind == KIND_PUSH_FRONT)
						free_blocks.push_front(blk);
					else
						free_blocks.push_back(blk);
					o.result_block = blk;
				end
			end
			KIND_POP_FRONT: begin
				if (free_blocks.size() == 0)
					o.status = ST_EMPTY;
				else
					o.result_block = free_blocks.pop_front();
			end
			KIND_REMOVE, KIND_FIND: begin
				// match nearest the front wins
				for (int i = 0; i < free_blocks.size(); i++) begin
					if (hit < 0 && free_blocks[i] == blk)
						hit = i;
				end
				if (hit < 0) begin
					o.status = ST_MISSING;
				end else begin
					o.result_block = free_blocks[hit];
					if (r.kind == KIND_REMOVE)
						free_blocks.delete(hit);
				end
			end
			default: ;
		endcase
		o.entry_count = ENTRY_COUNT_W'(free_blocks.size());
		return o;
	endfunction

	task automatic report_word(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected status %0d block %h count %0d, got status %0d block %h count %0d",
				what, want.status, want.result_block, want.entry_count,
				got.status, got.result_block, got.entry_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			free_blocks.delete();
			awaited_rsp.delete();
			awaited_words = 0;
		end else begin
			if (req_valid && req_ready)
				awaited_rsp.push_back(apply_request(req));
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					report_word("unexpected word", '0, rsp);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status ||
					    rsp.result_block !== want.result_block ||
					    rsp.entry_count !== want.entry_count)
						report_word("word mismatch", want, rsp);
				end
			end
			awaited_words = awaited_rsp.size();
		end
	end

endmodule

>>> verif/bounded_free_list_test.sv
// ----------------------------------------------------------------------------
// bounded_free_list_test: stimulus and verdict for the bounded free list
// Directed corner requests, then phases of random requests that alternate
// between filling and draining the list, with random stalls on both sides.
// ----------------------------------------------------------------------------
module bounded_free_list_test;
	import bfl_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam int PHASE_LEN    = 90;
	localparam int PHASES       = 15;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic idle_on = 1'b1;
	int   stall_left = 0;
	int   cycles = 0;
	int   mismatches;
	int   awaited_words;

	bounded_free_list DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	bounded_free_list_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.awaited_words (awaited_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Response back-pressure: ready drops in random bursts while idling is on.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			rsp_ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic req_t make_req(input logic [KIND_W-1:0] k,
	                                  input logic [BLOCK_ID_W-1:0] b);
		req_t r;
		r.kind     = k;
		r.block_id = b;
		return r;
	endfunction

	// Hold the word until taken, then maybe drop valid for a short gap.
	task automatic send_request(input req_t item);
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (idle_on && $urandom_range(0, 99) < 20) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	endtask

	// Filling phases lean on pushes so the list hits full; draining ones on pops.
	function automatic req_t random_req(input bit filling);
		logic [KIND_W-1:0]     k;
		logic [BLOCK_ID_W-1:0] b;
		int                    roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			k = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
		else if (roll < (filling ? 75 : 25))
			k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		else if (roll < (filling ? 82 : 60))
			k = KIND_POP_FRONT;
		else if (roll < (filling ? 91 : 80))
			k = KIND_REMOVE;
		else
			k = KIND_FIND;
		// a small pool of numbers gives duplicates and frequent hits
		if ($urandom_range(0, 99) < 70)
			b = BLOCK_ID_W'($urandom_range(0, 15));
		else
			b = BLOCK_ID_W'($urandom);
		return make_req(k, b);
	endfunction

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// empty list corners
		send_request(make_req(KIND_POP_FRONT, 16'hFFFF));
		send_request(make_req(KIND_REMOVE, 16'h0000));
		send_request(make_req(KIND_FIND, 16'hFFFF));
		// extremes, duplicates and nearest-front matching
		send_request(make_req(KIND_PUSH_BACK, 16'hFFFF));
		send_request(make_req(KIND_PUSH_FRONT, 16'h0000));
		send_request(make_req(KIND_PUSH_BACK, 16'hA5A5));
		send_request(make_req(KIND_PUSH_FRONT, 16'hA5A5));
		send_request(make_req(KIND_FIND, 16'hA5A5));
		send_request(make_req(KIND_REMOVE, 16'hA5A5));
		send_request(make_req(KIND_FIND, 16'hA5A5));
		send_request(make_req(KIND_FIND, 16'hFFFF));
		send_request(make_req(KIND_FIND, 16'h1234));
		send_request(make_req(KIND_REMOVE, 16'h1234));
		// unused request codes
		send_request(make_req(KIND_SPARE_FIRST, 16'hFFFF));
		send_request(make_req(KIND_SPARE_FIRST + 3'd1, 16'h0000));
		send_request(make_req(KIND_SPARE_LAST, 16'h5A5A));
		// drain past empty
		send_request(make_req(KIND_POP_FRONT, 16'h0000));
		send_request(make_req(KIND_REMOVE, 16'hFFFF));
		send_request(make_req(KIND_POP_FRONT, 16'h0000));
		send_request(make_req(KIND_POP_FRONT, 16'h0000));
		send_request(make_req(KIND_PUSH_FRONT, 16'h8001));
		send_request(make_req(KIND_REMOVE, 16'h8001));

		for (int p = 0; p < PHASES; p++) begin
			// every fourth phase and the last run without idling
			idle_on = (p % 4 != 3) && (p != PHASES - 1);
			for (int n = 0; n < PHASE_LEN; n++)
				send_request(random_req(p % 2 == 0));
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_words != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
